// ===== rtl/hcbe_pkg.sv =====
package hcbe_pkg;

	localparam int MAX_DIM = 4;
	localparam int DIM_W = 3;
	localparam int POS_W = 2;
	localparam int CNT_W = 3;
	localparam int CHAR_W = 8;
	localparam int KEY_W = 8;
	localparam int SUM_W = 18;
	localparam int KIDX_W = 4;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	typedef enum logic [1:0] {
		REG_KEY_DIM = 2'd0,
		REG_KEY_LOW = 2'd1,
		REG_KEY_HIGH = 2'd2,
		REG_NONE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic end_of_message;
	} char_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] cipher_value;
		logic block_end;
		logic message_end;
	} cipher_req_t;

	typedef struct packed {
		logic add;
		logic load;
		logic shift;
		logic last;
		logic msg_end;
	} cell_ctl_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] n;
		priority if (d == '0) begin
			n = DIM_W'(1);
		end else if (d > DIM_W'(MAX_DIM)) begin
			n = DIM_W'(MAX_DIM);
		end else begin
			n = d;
		end
		return n;
	endfunction

	function automatic logic [KEY_W-1:0] key_byte(input logic [DATA_W-1:0] lo,
			input logic [DATA_W-1:0] hi, input logic [KIDX_W-1:0] idx);
		logic [DATA_W-1:0] word;
		word = idx[3] ? hi : lo;
		word = word >> {idx[2:0], 3'b000};
		return word[KEY_W-1:0];
	endfunction

endpackage

// ===== rtl/hcbe_cfg.sv =====
module hcbe_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [hcbe_pkg::ADDR_W-1:0] paddr,
	input  logic [hcbe_pkg::DATA_W-1:0] pwdata,
	output logic [hcbe_pkg::DATA_W-1:0] prdata,
	output logic pready,
	output logic [hcbe_pkg::DIM_W-1:0] key_dim,
	output logic [hcbe_pkg::DATA_W-1:0] key_low,
	output logic [hcbe_pkg::DATA_W-1:0] key_high
);

	logic [hcbe_pkg::DIM_W-1:0] key_dim_q;
	logic [hcbe_pkg::DATA_W-1:0] key_low_q;
	logic [hcbe_pkg::DATA_W-1:0] key_high_q;
	hcbe_pkg::reg_idx_t idx;
	logic wr;

	assign idx = hcbe_pkg::reg_idx_t'(paddr[4:3]);
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_dim_q <= hcbe_pkg::DIM_W'(1);
			key_low_q <= '0;
			key_high_q <= '0;
		end else if (wr) begin
			unique case (idx)
				hcbe_pkg::REG_KEY_DIM: key_dim_q <= pwdata[hcbe_pkg::DIM_W-1:0];
				hcbe_pkg::REG_KEY_LOW: key_low_q <= pwdata;
				hcbe_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			hcbe_pkg::REG_KEY_DIM: prdata = {{(hcbe_pkg::DATA_W-hcbe_pkg::DIM_W){1'b0}},
				key_dim_q};
			hcbe_pkg::REG_KEY_LOW: prdata = key_low_q;
			hcbe_pkg::REG_KEY_HIGH: prdata = key_high_q;
			default: prdata = '0;
		endcase
	end

	assign key_dim = key_dim_q;
	assign key_low = key_low_q;
	assign key_high = key_high_q;

endmodule

// ===== rtl/hcbe_cell.sv =====
module hcbe_cell (
	input  logic clk,
	input  logic arst_n,
	input  hcbe_pkg::cell_ctl_t ctl,
	input  logic [hcbe_pkg::CHAR_W-1:0] char_code,
	input  logic [hcbe_pkg::KEY_W-1:0] key,
	input  hcbe_pkg::cipher_req_t nxt,
	output hcbe_pkg::cipher_req_t out
);

	logic [hcbe_pkg::CHAR_W+hcbe_pkg::KEY_W-1:0] prod;
	logic [hcbe_pkg::SUM_W-1:0] sum;
	logic [hcbe_pkg::SUM_W-1:0] acc_q;
	logic [hcbe_pkg::SUM_W-1:0] acc_nxt;
	hcbe_pkg::cipher_req_t out_q;

	assign prod = char_code * key;
	assign sum = acc_q + hcbe_pkg::SUM_W'(prod);
	assign acc_nxt = ctl.add ? sum : acc_q;

	// column sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.load) begin
			acc_q <= '0;
		end else if (ctl.add) begin
			acc_q <= sum;
		end
	end

	// output chain stage, shifts toward cell 0
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			out_q <= '{cipher_value: acc_nxt, block_end: ctl.last, message_end: ctl.msg_end};
		end else if (ctl.shift) begin
			out_q <= nxt;
		end
	end

	assign out = out_q;

endmodule

// ===== rtl/hill_cipher_block_encrypt.sv =====
// Latency: a block-closing request shows its first result on the next cycle; the n results
// of a block shift out of the column cells on consecutive cycles while cipher_ready holds.
// Throughput: one request per cycle while blocks are full; a request that closes a block
// waits until the shift chain holds at most one result that leaves in that cycle.
// Reset: key_dim = 1, key registers, column sums and block position cleared, chain empty.
module hill_cipher_block_encrypt (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [hcbe_pkg::ADDR_W-1:0] paddr,
	input  logic [hcbe_pkg::DATA_W-1:0] pwdata,
	output logic [hcbe_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic char_valid,
	output logic char_ready,
	input  hcbe_pkg::char_req_t char_req,
	output logic cipher_valid,
	input  logic cipher_ready,
	output hcbe_pkg::cipher_req_t cipher_req
);

	logic [hcbe_pkg::DIM_W-1:0] key_dim;
	logic [hcbe_pkg::DATA_W-1:0] key_low;
	logic [hcbe_pkg::DATA_W-1:0] key_high;
	logic [hcbe_pkg::DIM_W-1:0] n;
	logic [hcbe_pkg::POS_W-1:0] pos_q;
	logic [hcbe_pkg::CNT_W-1:0] cnt_q;
	logic [hcbe_pkg::DIM_W-1:0] pos_inc;
	logic [hcbe_pkg::KIDX_W-1:0] row_base;
	logic add_row;
	logic close;
	logic chain_free;
	logic accept;
	logic pop;
	logic load;
	hcbe_pkg::cipher_req_t chain [hcbe_pkg::MAX_DIM+1];

	hcbe_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.key_dim(key_dim),
		.key_low(key_low),
		.key_high(key_high)
	);

	assign n = hcbe_pkg::eff_dim(key_dim);
	assign pos_inc = {1'b0, pos_q} + hcbe_pkg::DIM_W'(1);
	assign add_row = {1'b0, pos_q} < n;
	assign close = (pos_inc >= n) | char_req.end_of_message;
	assign row_base = hcbe_pkg::KIDX_W'(pos_q) * hcbe_pkg::KIDX_W'(n);

	assign cipher_valid = cnt_q != '0;
	assign pop = cipher_valid & cipher_ready;
	assign chain_free = (cnt_q == '0) | ((cnt_q == hcbe_pkg::CNT_W'(1)) & cipher_ready);
	assign char_ready = !close | chain_free;
	assign accept = char_valid & char_ready;
	assign load = accept & close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				pos_q <= close ? '0 : pos_inc[hcbe_pkg::POS_W-1:0];
			end
			if (load) begin
				cnt_q <= hcbe_pkg::CNT_W'(n);
			end else if (pop) begin
				cnt_q <= cnt_q - hcbe_pkg::CNT_W'(1);
			end
		end
	end

	assign chain[hcbe_pkg::MAX_DIM] = '0;

	for (genvar j = 0; j < hcbe_pkg::MAX_DIM; j++) begin : g_cell
		hcbe_pkg::cell_ctl_t ctl;
		logic [hcbe_pkg::KEY_W-1:0] key;
		logic col_on;
		logic last;

		assign col_on = hcbe_pkg::DIM_W'(j) < n;
		assign last = (hcbe_pkg::DIM_W'(j) + hcbe_pkg::DIM_W'(1)) == n;
		assign key = hcbe_pkg::key_byte(key_low, key_high,
			row_base + hcbe_pkg::KIDX_W'(j));
		assign ctl = '{
			add: accept & add_row & col_on,
			load: load,
			shift: pop,
			last: last,
			msg_end: last & char_req.end_of_message
		};

		hcbe_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(ctl),
			.char_code(char_req.char_code),
			.key(key),
			.nxt(chain[j+1]),
			.out(chain[j])
		);
	end

	assign cipher_req = chain[0];

endmodule

// ===== rtl/hcbe_checker.sv =====
module hcbe_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic char_valid,
	input  logic char_ready,
	input  hcbe_pkg::char_req_t char_req,
	input  logic cipher_valid,
	input  logic cipher_ready,
	input  hcbe_pkg::cipher_req_t cipher_req
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && !cipher_ready |=> cipher_valid && $stable(cipher_req))
		else $error("result changed while stalled");

	a_msg_on_block: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid |-> !(cipher_req.message_end && !cipher_req.block_end))
		else $error("message end off a block end");

	a_eom_result: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid && char_ready && char_req.end_of_message |=> cipher_valid)
		else $error("no result after end of message");

	a_block_cont: assert property (@(posedge clk) disable iff (!arst_n)
		cipher_valid && cipher_ready && !cipher_req.block_end |=> cipher_valid)
		else $error("gap inside a block");

endmodule

bind hill_cipher_block_encrypt hcbe_checker u_hcbe_checker (.*);
